// ===== design/usb_config_descriptor_parser_macros.svh =====
// Assertion macros used by the checker file.
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define UCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define UCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/ucdp_pkg.sv =====
// Shared types and constants of the USB configuration descriptor parser.
package ucdp_pkg;
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  localparam logic [7:0] KIND_INTERFACE = 8'd4;
  localparam logic [7:0] KIND_ENDPOINT  = 8'd5;
  localparam int IN_W  = 16;
  localparam int OUT_W = 72;

  typedef struct packed {
    logic [7:0]  interval;
    logic [15:0] max_size;
    logic [1:0]  ep_type;
    logic [7:0]  address;
  } ep_word_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
    logic       is_last;
    logic [1:0] want_type;
    logic       want_in;
  } cmd_t;
endpackage

// ===== design/ucdp_front.sv =====
// Front part: accepts input transfers, decodes them and feeds a two-entry queue.
module ucdp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ucdp_pkg::IN_W-1:0]  in_tdata,
  output logic                       q_valid,
  input  logic                       q_pop,
  output ucdp_pkg::cmd_t             q_cmd
);
  import ucdp_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.func      = func_t'(in_tdata[1:0]);
    dec.data_byte = in_tdata[9:2];
    dec.is_last   = in_tdata[10];
    dec.want_type = in_tdata[12:11];
    dec.want_in   = in_tdata[13];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end
endmodule

// ===== design/ucdp_back.sv =====
// Back part: walks descriptors, keeps the endpoint table and answers finds.
module ucdp_back #(
  parameter int MAX_ENDPOINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  ucdp_pkg::cmd_t           q_cmd,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [ucdp_pkg::OUT_W-1:0] out_tdata
);
  import ucdp_pkg::*;

  localparam int IW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int CW = $clog2(MAX_ENDPOINTS + 1);

  logic [7:0]  byte_pos_r, byte_pos_nxt, desc_len_r, desc_len_nxt;
  logic [7:0]  desc_kind_r, desc_kind_nxt, cap_alt_r, cap_alt_nxt;
  logic [23:0] cap_codes_r, cap_codes_nxt, iface_r, iface_nxt;
  ep_word_t    cap_ep_r, cap_ep_nxt;
  logic        saw_r, saw_nxt, stop_r, stop_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ep_word_t    table_r [MAX_ENDPOINTS];
  logic        tbl_we;
  logic        hit;
  ep_word_t    found;
  logic        ov_r;
  logic [OUT_W-1:0] od_r, od_nxt;
  logic [7:0]  b, kind_now, len_now;
  logic        done;

  assign q_pop = q_valid && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign b = q_cmd.data_byte;

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    desc_len_nxt  = desc_len_r;
    desc_kind_nxt = desc_kind_r;
    cap_alt_nxt   = cap_alt_r;
    cap_codes_nxt = cap_codes_r;
    cap_ep_nxt    = cap_ep_r;
    saw_nxt       = saw_r;
    stop_nxt      = stop_r;
    iface_nxt     = iface_r;
    cnt_nxt       = cnt_r;
    tbl_we        = 1'b0;
    kind_now      = desc_kind_r;
    len_now       = desc_len_r;
    done          = 1'b0;
    case (q_cmd.func)
      FUNC_CLEAR: begin
        byte_pos_nxt  = '0;
        desc_len_nxt  = '0;
        desc_kind_nxt = '0;
        cap_alt_nxt   = '0;
        cap_codes_nxt = '0;
        cap_ep_nxt    = '0;
        saw_nxt       = 1'b0;
        stop_nxt      = 1'b0;
        iface_nxt     = '0;
        cnt_nxt       = '0;
      end
      FUNC_BYTE: begin
        if (!stop_r) begin
          if (byte_pos_r == 8'd0) begin
            len_now       = b;
            kind_now      = '0;
            desc_len_nxt  = b;
            desc_kind_nxt = '0;
            cap_alt_nxt   = '0;
            cap_codes_nxt = '0;
            cap_ep_nxt    = '0;
          end else begin
            if (byte_pos_r == 8'd1) begin
              kind_now      = b;
              desc_kind_nxt = b;
            end
            if (kind_now == KIND_INTERFACE) begin
              case (byte_pos_r)
                8'd3: cap_alt_nxt = b;
                8'd5: cap_codes_nxt[23:16] = b;
                8'd6: cap_codes_nxt[15:8] = b;
                8'd7: cap_codes_nxt[7:0] = b;
                default: ;
              endcase
            end else if (kind_now == KIND_ENDPOINT) begin
              case (byte_pos_r)
                8'd2: cap_ep_nxt.address = b;
                8'd3: cap_ep_nxt.ep_type = b[1:0];
                8'd4: cap_ep_nxt.max_size[7:0] = b;
                8'd5: cap_ep_nxt.max_size[15:8] = b;
                8'd6: cap_ep_nxt.interval = b;
                default: ;
              endcase
            end
          end
          if (byte_pos_r == 8'd0 && b == 8'd0) begin
            stop_nxt = 1'b1;
          end else begin
            done = ({1'b0, byte_pos_r} + 9'd1) >= {1'b0, len_now};
            if (done) begin
              byte_pos_nxt = '0;
              if (kind_now == KIND_INTERFACE && len_now >= 8'd9) begin
                if (!saw_r || cap_alt_nxt == 8'd0) begin
                  iface_nxt = cap_codes_nxt;
                  saw_nxt   = 1'b1;
                end
              end else if (kind_now == KIND_ENDPOINT && len_now >= 8'd7) begin
                if (cnt_r < CW'(MAX_ENDPOINTS)) begin
                  tbl_we  = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
            end else begin
              byte_pos_nxt = byte_pos_r + 8'd1;
            end
            if (q_cmd.is_last) stop_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int i = MAX_ENDPOINTS - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_r && table_r[i].ep_type == q_cmd.want_type &&
          table_r[i].address[7] == q_cmd.want_in) begin
        hit   = 1'b1;
        found = table_r[i];
      end
    end
    if (q_cmd.func != FUNC_FIND) begin
      hit   = 1'b0;
      found = '0;
    end
  end

  always_comb begin
    od_nxt = {7'd0, stop_nxt, found.interval, found.max_size, found.ep_type,
              found.address, hit, 5'(cnt_nxt), iface_nxt[7:0],
              iface_nxt[15:8], iface_nxt[23:16]};
  end

  always_ff @(posedge clk) begin
    if (q_pop && tbl_we) table_r[cnt_r[IW-1:0]] <= cap_ep_nxt;
    if (q_pop) od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0; desc_len_r <= '0; desc_kind_r <= '0; cap_alt_r <= '0;
      cap_codes_r <= '0; cap_ep_r <= '0; saw_r <= 1'b0; stop_r <= 1'b0;
      iface_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (q_pop) begin
        byte_pos_r <= byte_pos_nxt; desc_len_r <= desc_len_nxt;
        desc_kind_r <= desc_kind_nxt; cap_alt_r <= cap_alt_nxt;
        cap_codes_r <= cap_codes_nxt; cap_ep_r <= cap_ep_nxt; saw_r <= saw_nxt;
        stop_r <= stop_nxt; iface_r <= iface_nxt; cnt_r <= cnt_nxt;
      end
      if (q_pop) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end
endmodule

// ===== design/usb_config_descriptor_parser.sv =====
// Top level of the USB configuration descriptor parser.
// Each input transfer yields exactly one output transfer, which becomes valid after the
// item has passed through the queue and the back end's output register. A two-entry queue
// decouples the input from the parsing back end, which takes one queued item per cycle
// whenever its registered output is empty or being accepted, so items flow at one per clock
// while out_tready stays high. A stalled output holds the back end; the queue then fills
// both of its entries before in_tready drops. A find compares all endpoint table entries
// in parallel and returns the lowest matching one.
module usb_config_descriptor_parser #(
  parameter int MAX_ENDPOINTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // func[1:0], data_byte[9:2], is_last[10], want_type[12:11], want_in[13], zero pad.
  input  logic [ucdp_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // iface_class[7:0], iface_subclass[15:8], iface_protocol[23:16], endpoint_total[28:24],
  // hit[29], hit_address[37:30], hit_type[39:38], hit_max_size[55:40],
  // hit_interval[63:56], halted[64], zero pad.
  output logic [ucdp_pkg::OUT_W-1:0] out_tdata
);
  import ucdp_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  ucdp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .q_valid, .q_pop, .q_cmd
  );

  ucdp_back #(.MAX_ENDPOINTS(MAX_ENDPOINTS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_tvalid, .out_tready, .out_tdata
  );
endmodule

// ===== design/ucdp_checker.sv =====
// Port-level checker for the USB configuration descriptor parser, with its bind.
`include "usb_config_descriptor_parser_macros.svh"
module ucdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  `UCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "held data changed")
  `UCD_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "valid dropped")
  `UCD_ASSERT_IMP(a_nohit_zero, clk, rst_n, out_tvalid && !out_tdata[29], out_tdata[63:30] == 34'd0, "hit fields without hit")
  `UCD_ASSERT_NEXT(a_resp, clk, rst_n, in_tvalid && in_tready && !out_tvalid, ##1 out_tvalid, "no result for transfer")
endmodule

bind usb_config_descriptor_parser ucdp_checker u_chk (.*);
